[rtl/core/bmp_stream_to_rgba_decoder_core_assert.svh]
// Assertion macros for the BMP stream decoder.
// Used by the top level only; needs nothing else.
`ifndef BMP_STREAM_TO_RGBA_DECODER_CORE_ASSERT_SVH
`define BMP_STREAM_TO_RGBA_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BSRD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("bsrd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BSRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("bsrd assertion failed");

`endif

[rtl/core/bsrd_pkg.sv]
// Shared constants and controller/datapath interface types of the BMP decoder.
// Depends on nothing.
`timescale 1ns / 1ps

package bsrd_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 4096;
  localparam int unsigned MAX_HEIGHT_DEF = 4096;
  localparam int unsigned COORD_W        = 12;
  localparam int unsigned CFG_ADDR_W     = 3;

  localparam logic REG_FILE_BYTES = 1'b0;

  localparam logic [3:0] ST_PIXEL        = 4'd0;
  localparam logic [3:0] ST_NOT_BMP      = 4'd1;
  localparam logic [3:0] ST_BAD_DIMS     = 4'd2;
  localparam logic [3:0] ST_DEPTH        = 4'd3;
  localparam logic [3:0] ST_COMPRESSION  = 4'd4;
  localparam logic [3:0] ST_BF_NOT_32    = 4'd5;
  localparam logic [3:0] ST_NO_MASKS     = 4'd6;
  localparam logic [3:0] ST_BAD_MASKS    = 4'd7;
  localparam logic [3:0] ST_EXCEEDS_FILE = 4'd8;
  localparam logic [3:0] ST_TOO_LARGE    = 4'd9;
  localparam logic [3:0] ST_OVERLAP      = 4'd10;

  localparam logic [31:0] OFS_PIX_START = 32'h0A;
  localparam logic [31:0] OFS_INFO      = 32'h0E;
  localparam logic [31:0] OFS_WIDTH     = 32'h12;
  localparam logic [31:0] OFS_HEIGHT    = 32'h16;
  localparam logic [31:0] OFS_BPP       = 32'h1C;
  localparam logic [31:0] OFS_COMP      = 32'h1E;
  localparam logic [31:0] OFS_HDR_LAST  = 32'h35;
  localparam logic [31:0] HDR_END_RGB   = 32'h36;
  localparam logic [31:0] HDR_END_BF    = 32'h42;
  localparam logic [31:0] HDR_END_ALPHA = 32'h46;
  localparam logic [31:0] INFO_V4_SIZE  = 32'd108;

  localparam logic [7:0]  MAGIC_B = 8'h42;
  localparam logic [7:0]  MAGIC_M = 8'h4D;

  localparam logic [15:0] BPP_24 = 16'd24;
  localparam logic [15:0] BPP_32 = 16'd32;
  localparam logic [31:0] COMP_RGB       = 32'd0;
  localparam logic [31:0] COMP_BITFIELDS = 32'd3;

  localparam logic [31:0] MASK_RED   = 32'h00FF0000;
  localparam logic [31:0] MASK_GREEN = 32'h0000FF00;
  localparam logic [31:0] MASK_BLUE  = 32'h000000FF;
  localparam logic [31:0] MASK_ALPHA = 32'hFF000000;

  typedef struct packed {
    logic       capture;
    logic       advance;
    logic       pix_step;
    logic       pix_init;
    logic       load_area;
    logic       hend_hdr;
    logic       hend_msk;
    logic       mul;
    logic       emit_err;
    logic [3:0] err_code;
  } cmd_t;

  typedef struct packed {
    logic       err_magic;
    logic       hdr_last;
    logic       mask_last;
    logic       skip_last;
    logic       eof;
    logic       to_masks;
    logic       start_pix;
    logic       pix_last;
    logic       out_free;
    logic [3:0] hdr_code;
    logic [3:0] msk_code;
    logic [3:0] fit_code;
  } sts_t;

endpackage

[rtl/core/bmp_stream_to_rgba_decoder_core.sv]
// Top level of the BMP stream decoder: configuration port, controller and datapath.
// Depends on bsrd_pkg, bsrd_ctrl, bsrd_dp and the assertion macro header.
`timescale 1ns / 1ps
// Usage: write the file length to register file_bytes (byte address 0) while the block
// is idle, then stream the file one byte per transfer on the input channel
// (in_valid_i, in_stall_o, file_byte_i). Results leave on the output channel
// (out_valid_o, out_stall_i) as one pixel per 3 or 4 pixel bytes, or as one error
// status with last set, after which the rest of that file is consumed silently.
// Without receiver stalls, a pixel or a not-BMP status is valid on the cycle after the
// byte that completes it. A header check status follows byte 0x35 through S_CHK_HDR,
// a mask status follows the last mask byte through S_CHK_MSK, and a fit, size or overlap
// status follows the byte that ends the examined header through S_CHK_MUL and S_CHK_FIT.
// Throughput: one byte per cycle while the input is not stalled. The byte that ends the
// examined header holds the input while the header or mask checks run and the fit check
// runs through the 32 by 32 bit multiplier; for bitfield images byte 0x35 holds it while
// S_CHK_HDR runs. The output register holds a result while the receiver stalls, and the
// input stalls as long as a result waits there.
// Reset clears the register to zero, empties the output register and starts a new
// file at offset zero. After the final byte of a file the next byte starts a new file.
module bmp_stream_to_rgba_decoder_core #(
  parameter int unsigned MAX_WIDTH  = bsrd_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = bsrd_pkg::MAX_HEIGHT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bsrd_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [7:0]                       file_byte_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [3:0]                       status_o,
  output logic [7:0]                       red_o,
  output logic [7:0]                       green_o,
  output logic [7:0]                       blue_o,
  output logic [7:0]                       alpha_o,
  output logic [bsrd_pkg::COORD_W-1:0]     column_o,
  output logic [bsrd_pkg::COORD_W-1:0]     row_o,
  output logic                             last_o
);

`include "bmp_stream_to_rgba_decoder_core_assert.svh"

  logic [31:0]    file_bytes_q;
  logic           reg_hit;
  bsrd_pkg::cmd_t cmd;
  bsrd_pkg::sts_t sts;

  assign pready  = 1'b1;
  assign reg_hit = paddr[bsrd_pkg::CFG_ADDR_W-1] == bsrd_pkg::REG_FILE_BYTES;
  assign prdata  = reg_hit ? file_bytes_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_bytes_q <= '0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      file_bytes_q <= pwdata;
    end
  end

  bsrd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bsrd_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .file_bytes_i (file_bytes_q),
    .file_byte_i  (file_byte_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .status_o     (status_o),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .alpha_o      (alpha_o),
    .column_o     (column_o),
    .row_o        (row_o),
    .last_o       (last_o)
  );

  `BSRD_ASSERT_IMPL(a_err_fields, clk_i, rst_ni, out_valid_o && (status_o != bsrd_pkg::ST_PIXEL), last_o && (column_o == '0) && (row_o == '0) && (alpha_o == 8'd0))
  `BSRD_ASSERT_IMPL(a_status_range, clk_i, rst_ni, out_valid_o, status_o <= bsrd_pkg::ST_OVERLAP)
  `BSRD_ASSERT_IMPL(a_no_accept_blocked, clk_i, rst_ni, in_valid_i && !in_stall_o, !(out_valid_o && out_stall_i))
  `BSRD_ASSERT_NEXT(a_idle_drains, clk_i, rst_ni, out_valid_o && !out_stall_i && !in_valid_i && !in_stall_o, !out_valid_o)

endmodule

[rtl/core/bsrd_ctrl.sv]
// Controller of the BMP decoder: decode phase and check sequencing.
// Depends on bsrd_pkg; drives the datapath through bsrd_pkg::cmd_t.
`timescale 1ns / 1ps

module bsrd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bsrd_pkg::sts_t sts_i,
  output bsrd_pkg::cmd_t cmd_o
);

  localparam logic [3:0] S_HEADER  = 4'd0;
  localparam logic [3:0] S_MASKS   = 4'd1;
  localparam logic [3:0] S_SKIP    = 4'd2;
  localparam logic [3:0] S_PIXELS  = 4'd3;
  localparam logic [3:0] S_DONE    = 4'd4;
  localparam logic [3:0] S_CHK_HDR = 4'd5;
  localparam logic [3:0] S_CHK_MSK = 4'd6;
  localparam logic [3:0] S_CHK_MUL = 4'd7;
  localparam logic [3:0] S_CHK_FIT = 4'd8;

  logic [3:0] state_q, state_d;
  logic       phase_st;
  logic       acc;

  assign phase_st = (state_q == S_HEADER) || (state_q == S_MASKS) || (state_q == S_SKIP) ||
                    (state_q == S_PIXELS) || (state_q == S_DONE);
  assign in_stall_o = !phase_st || !sts_i.out_free;
  assign acc = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_HEADER: begin
        if (acc) begin
          cmd_o.capture = 1'b1;
          if (sts_i.err_magic) begin
            cmd_o.emit_err = 1'b1;
            cmd_o.err_code = bsrd_pkg::ST_NOT_BMP;
            cmd_o.advance  = 1'b1;
            state_d = sts_i.eof ? S_HEADER : S_DONE;
          end else if (sts_i.hdr_last) begin
            state_d = S_CHK_HDR;
          end else begin
            cmd_o.advance = 1'b1;
          end
        end
      end
      S_CHK_HDR: begin
        if (sts_i.out_free) begin
          cmd_o.load_area = 1'b1;
          cmd_o.hend_hdr  = 1'b1;
          if (sts_i.hdr_code != bsrd_pkg::ST_PIXEL) begin
            cmd_o.emit_err = 1'b1;
            cmd_o.err_code = sts_i.hdr_code;
            cmd_o.advance  = 1'b1;
            state_d = sts_i.eof ? S_HEADER : S_DONE;
          end else if (sts_i.to_masks) begin
            cmd_o.advance = 1'b1;
            state_d = sts_i.eof ? S_HEADER : S_MASKS;
          end else begin
            state_d = S_CHK_MUL;
          end
        end
      end
      S_MASKS: begin
        if (acc) begin
          cmd_o.capture = 1'b1;
          if (sts_i.mask_last) begin
            state_d = S_CHK_MSK;
          end else begin
            cmd_o.advance = 1'b1;
            state_d = sts_i.eof ? S_HEADER : S_MASKS;
          end
        end
      end
      S_CHK_MSK: begin
        if (sts_i.out_free) begin
          cmd_o.load_area = 1'b1;
          cmd_o.hend_msk  = 1'b1;
          if (sts_i.msk_code != bsrd_pkg::ST_PIXEL) begin
            cmd_o.emit_err = 1'b1;
            cmd_o.err_code = sts_i.msk_code;
            cmd_o.advance  = 1'b1;
            state_d = sts_i.eof ? S_HEADER : S_DONE;
          end else begin
            state_d = S_CHK_MUL;
          end
        end
      end
      S_CHK_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = S_CHK_FIT;
      end
      S_CHK_FIT: begin
        if (sts_i.out_free) begin
          cmd_o.advance = 1'b1;
          if (sts_i.fit_code != bsrd_pkg::ST_PIXEL) begin
            cmd_o.emit_err = 1'b1;
            cmd_o.err_code = sts_i.fit_code;
            state_d = sts_i.eof ? S_HEADER : S_DONE;
          end else begin
            cmd_o.pix_init = 1'b1;
            state_d = sts_i.eof ? S_HEADER : (sts_i.start_pix ? S_PIXELS : S_SKIP);
          end
        end
      end
      S_SKIP: begin
        if (acc) begin
          cmd_o.advance = 1'b1;
          state_d = sts_i.eof ? S_HEADER : (sts_i.skip_last ? S_PIXELS : S_SKIP);
        end
      end
      S_PIXELS: begin
        if (acc) begin
          cmd_o.pix_step = 1'b1;
          cmd_o.advance  = 1'b1;
          state_d = sts_i.eof ? S_HEADER : (sts_i.pix_last ? S_DONE : S_PIXELS);
        end
      end
      S_DONE: begin
        if (acc) begin
          cmd_o.advance = 1'b1;
          state_d = sts_i.eof ? S_HEADER : S_DONE;
        end
      end
      default: begin
        state_d = S_HEADER;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_HEADER;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/core/bsrd_dp.sv]
// Datapath of the BMP decoder: header fields, area check, pixel assembly, result register.
// Depends on bsrd_pkg; commanded by bsrd_ctrl.
`timescale 1ns / 1ps

module bsrd_dp #(
  parameter int unsigned MAX_WIDTH  = bsrd_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = bsrd_pkg::MAX_HEIGHT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bsrd_pkg::cmd_t                cmd_i,
  output bsrd_pkg::sts_t                sts_o,
  input  logic [31:0]                   file_bytes_i,
  input  logic [7:0]                    file_byte_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [3:0]                    status_o,
  output logic [7:0]                    red_o,
  output logic [7:0]                    green_o,
  output logic [7:0]                    blue_o,
  output logic [7:0]                    alpha_o,
  output logic [bsrd_pkg::COORD_W-1:0]  column_o,
  output logic [bsrd_pkg::COORD_W-1:0]  row_o,
  output logic                          last_o
);

  localparam int unsigned COL_W    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned ROW_W    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned STRIDE_W = $clog2(4 * MAX_WIDTH + 4);

  logic [31:0] ofs_q;
  logic [31:0] pix_start_q, info_q, width_q, height_q, comp_q;
  logic [15:0] bpp_q;
  logic [31:0] mask_q [4];
  logic [33:0] stride_q, rowb_q;
  logic [31:0] habs_q;
  logic        bpb4_q;
  logic [6:0]  hend_q;
  logic [63:0] prod_q;

  logic [23:0]         gath_q;
  logic [1:0]          bip_q;
  logic [STRIDE_W-1:0] bir_q;
  logic [COL_W-1:0]    col_q;
  logic [ROW_W-1:0]    row_q;

  logic                        out_valid_q;
  logic [3:0]                  status_q;
  logic [7:0]                  red_q, green_q, blue_q, alpha_q;
  logic [bsrd_pkg::COORD_W-1:0] column_q, row_out_q;
  logic                        last_q;

  logic [32:0] o1;
  logic        alpha_rd;
  logic [31:0] abs_h;
  logic [33:0] wb, stride_c;
  logic [64:0] need;
  logic [31:0] alpha_mask;
  logic        in_row, pix_done, col_last, row_last;
  logic [STRIDE_W-1:0] bir1;
  logic        row_end;
  logic [31:0] dst_row, col_ext;
  logic        restart, load_out;
  logic [31:0] rel_mask;
  logic [1:0]  lane;

  assign o1       = {1'b0, ofs_q} + 33'd1;
  assign alpha_rd = (info_q >= bsrd_pkg::INFO_V4_SIZE) &&
                    (file_bytes_i >= bsrd_pkg::HDR_END_ALPHA);
  assign abs_h    = height_q[31] ? (32'd0 - height_q) : height_q;
  assign wb       = bpp_q == bsrd_pkg::BPP_32 ? {width_q, 2'b00}
                                              : ({1'b0, width_q, 1'b0} + {2'b00, width_q});
  assign stride_c = (wb + 34'd3) & ~34'd3;
  assign need     = {1'b0, prod_q} + {33'd0, pix_start_q};
  assign alpha_mask = alpha_rd ? mask_q[3] : 32'd0;
  assign rel_mask = ofs_q - bsrd_pkg::HDR_END_RGB;
  assign lane     = ofs_q[1:0] - bsrd_pkg::OFS_PIX_START[1:0];

  assign in_row   = bir_q < rowb_q[STRIDE_W-1:0];
  assign pix_done = in_row && (bpb4_q ? (bip_q == 2'd3) : (bip_q == 2'd2));
  assign col_ext  = {{(32-COL_W){1'b0}}, col_q};
  assign col_last = (col_ext + 32'd1) == width_q;
  assign row_last = ({{(32-ROW_W){1'b0}}, row_q} + 32'd1) == habs_q;
  assign bir1     = bir_q + {{(STRIDE_W-1){1'b0}}, 1'b1};
  assign row_end  = bir1 >= stride_q[STRIDE_W-1:0];
  assign dst_row  = height_q[31] ? {{(32-ROW_W){1'b0}}, row_q}
                                 : (habs_q - 32'd1 - {{(32-ROW_W){1'b0}}, row_q});

  assign restart  = cmd_i.advance && sts_o.eof;
  assign load_out = cmd_i.emit_err || (cmd_i.pix_step && pix_done);

  always_comb begin
    sts_o = '0;
    sts_o.eof       = o1 >= {1'b0, file_bytes_i};
    sts_o.err_magic = ((ofs_q == 32'd0) && ((file_bytes_i < bsrd_pkg::HDR_END_RGB) ||
                       (file_byte_i != bsrd_pkg::MAGIC_B))) ||
                      ((ofs_q == 32'd1) && (file_byte_i != bsrd_pkg::MAGIC_M));
    sts_o.hdr_last  = ofs_q == bsrd_pkg::OFS_HDR_LAST;
    sts_o.mask_last = o1 >= {1'b0, alpha_rd ? bsrd_pkg::HDR_END_ALPHA : bsrd_pkg::HDR_END_BF};
    sts_o.skip_last = o1 >= {1'b0, pix_start_q};
    sts_o.start_pix = o1 == {1'b0, pix_start_q};
    sts_o.to_masks  = comp_q == bsrd_pkg::COMP_BITFIELDS;
    sts_o.pix_last  = pix_done && col_last && row_last;
    sts_o.out_free  = !out_valid_q || !out_stall_i;

    priority if (width_q == 32'd0 || width_q[31] || height_q == 32'd0) begin
      sts_o.hdr_code = bsrd_pkg::ST_BAD_DIMS;
    end else if (bpp_q != bsrd_pkg::BPP_24 && bpp_q != bsrd_pkg::BPP_32) begin
      sts_o.hdr_code = bsrd_pkg::ST_DEPTH;
    end else if (comp_q != bsrd_pkg::COMP_RGB && comp_q != bsrd_pkg::COMP_BITFIELDS) begin
      sts_o.hdr_code = bsrd_pkg::ST_COMPRESSION;
    end else if (comp_q == bsrd_pkg::COMP_BITFIELDS && bpp_q != bsrd_pkg::BPP_32) begin
      sts_o.hdr_code = bsrd_pkg::ST_BF_NOT_32;
    end else if (comp_q == bsrd_pkg::COMP_BITFIELDS && file_bytes_i < bsrd_pkg::HDR_END_BF) begin
      sts_o.hdr_code = bsrd_pkg::ST_NO_MASKS;
    end else begin
      sts_o.hdr_code = bsrd_pkg::ST_PIXEL;
    end

    if (mask_q[0] != bsrd_pkg::MASK_RED || mask_q[1] != bsrd_pkg::MASK_GREEN ||
        mask_q[2] != bsrd_pkg::MASK_BLUE ||
        (alpha_mask != bsrd_pkg::MASK_ALPHA && alpha_mask != 32'd0)) begin
      sts_o.msk_code = bsrd_pkg::ST_BAD_MASKS;
    end else begin
      sts_o.msk_code = bsrd_pkg::ST_PIXEL;
    end

    priority if (stride_q[33:32] != 2'b00 || need > {33'd0, file_bytes_i}) begin
      sts_o.fit_code = bsrd_pkg::ST_EXCEEDS_FILE;
    end else if (width_q > 32'(MAX_WIDTH) || habs_q > 32'(MAX_HEIGHT)) begin
      sts_o.fit_code = bsrd_pkg::ST_TOO_LARGE;
    end else if (pix_start_q < {25'd0, hend_q}) begin
      sts_o.fit_code = bsrd_pkg::ST_OVERLAP;
    end else begin
      sts_o.fit_code = bsrd_pkg::ST_PIXEL;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      if (ofs_q >= bsrd_pkg::OFS_PIX_START && ofs_q < bsrd_pkg::OFS_INFO) begin
        pix_start_q[{lane, 3'b000} +: 8] <= file_byte_i;
      end else if (ofs_q >= bsrd_pkg::OFS_INFO && ofs_q < bsrd_pkg::OFS_WIDTH) begin
        info_q[{lane, 3'b000} +: 8] <= file_byte_i;
      end else if (ofs_q >= bsrd_pkg::OFS_WIDTH && ofs_q < bsrd_pkg::OFS_HEIGHT) begin
        width_q[{lane, 3'b000} +: 8] <= file_byte_i;
      end else if (ofs_q >= bsrd_pkg::OFS_HEIGHT && ofs_q < (bsrd_pkg::OFS_HEIGHT + 32'd4)) begin
        height_q[{lane, 3'b000} +: 8] <= file_byte_i;
      end else if (ofs_q >= bsrd_pkg::OFS_BPP && ofs_q < bsrd_pkg::OFS_COMP) begin
        bpp_q[{ofs_q[0], 3'b000} +: 8] <= file_byte_i;
      end else if (ofs_q >= bsrd_pkg::OFS_COMP && ofs_q < (bsrd_pkg::OFS_COMP + 32'd4)) begin
        comp_q[{lane, 3'b000} +: 8] <= file_byte_i;
      end else if (ofs_q >= bsrd_pkg::HDR_END_RGB && ofs_q < bsrd_pkg::HDR_END_ALPHA) begin
        mask_q[rel_mask[3:2]][{rel_mask[1:0], 3'b000} +: 8] <= file_byte_i;
      end
    end
    if (cmd_i.load_area) begin
      stride_q <= stride_c;
      rowb_q   <= wb;
      habs_q   <= abs_h;
      bpb4_q   <= bpp_q == bsrd_pkg::BPP_32;
    end
    if (cmd_i.hend_hdr) begin
      hend_q <= bsrd_pkg::HDR_END_RGB[6:0];
    end else if (cmd_i.hend_msk) begin
      hend_q <= alpha_rd ? bsrd_pkg::HDR_END_ALPHA[6:0] : bsrd_pkg::HDR_END_BF[6:0];
    end
    if (cmd_i.mul) begin
      prod_q <= stride_q[31:0] * habs_q;
    end
    if (load_out) begin
      if (cmd_i.emit_err) begin
        status_q  <= cmd_i.err_code;
        red_q     <= 8'd0;
        green_q   <= 8'd0;
        blue_q    <= 8'd0;
        alpha_q   <= 8'd0;
        column_q  <= '0;
        row_out_q <= '0;
        last_q    <= 1'b1;
      end else begin
        status_q  <= bsrd_pkg::ST_PIXEL;
        red_q     <= bpb4_q ? gath_q[23:16] : file_byte_i;
        green_q   <= gath_q[15:8];
        blue_q    <= gath_q[7:0];
        alpha_q   <= bpb4_q ? file_byte_i : 8'hFF;
        column_q  <= col_ext[bsrd_pkg::COORD_W-1:0];
        row_out_q <= dst_row[bsrd_pkg::COORD_W-1:0];
        last_q    <= sts_o.pix_last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ofs_q       <= '0;
      gath_q      <= '0;
      bip_q       <= '0;
      bir_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= load_out || (out_valid_q && out_stall_i);
      if (cmd_i.advance) begin
        ofs_q <= sts_o.eof ? 32'd0 : o1[31:0];
      end
      if (restart || cmd_i.pix_init) begin
        gath_q <= '0;
        bip_q  <= '0;
        bir_q  <= '0;
        col_q  <= '0;
        row_q  <= '0;
      end else if (cmd_i.pix_step) begin
        if (in_row) begin
          if (pix_done) begin
            gath_q <= '0;
            bip_q  <= '0;
          end else begin
            gath_q[{bip_q, 3'b000} +: 8] <= file_byte_i;
            bip_q <= bip_q + 2'd1;
          end
        end
        if (row_end) begin
          bir_q <= '0;
          col_q <= '0;
          row_q <= row_q + {{(ROW_W-1){1'b0}}, 1'b1};
        end else begin
          bir_q <= bir1;
          if (pix_done) begin
            col_q <= col_q + {{(COL_W-1){1'b0}}, 1'b1};
          end
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;
  assign alpha_o     = alpha_q;
  assign column_o    = column_q;
  assign row_o       = row_out_q;
  assign last_o      = last_q;

endmodule
